@@ rtl/sha1_pkg.sv @@
// package with the word types, sequencer states and constants of the sha-1 digest block
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_PAD2,
        ST_OUT
    } state_t;

    localparam int NUM_ROUNDS = 80;
    localparam int NUM_CHAIN  = 5;
    localparam int NUM_BLOCK  = 16;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

`default_nettype wire

@@ rtl/sha1_message_digest.sv @@
// sha-1 digest block: byte packing, padding, shared round unit and digest output
// sequence: a byte that does not fill a block is taken in idle; a byte that fills
// a 64-byte block is taken, then the 80 rounds run on one shared round unit,
// then the chain add; an end of message adds a pad step and one compression,
// or two when the length spills into an extra block, then the five digest words go
// out one per cycle as the output allows
// input: no new byte is taken until the block is back in idle; msg_stall is high meanwhile
// reset: chain words go to the sha-1 initial values, byte count to zero, idle and ready
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest
    import sha1_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_stall,
    input  wire msg_word_t    msg,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_word_t      digest
);

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [6:0]   round_reg, round_next;
    logic [2:0]   idx_reg, idx_next;
    logic [60:0]  count_reg, count_next;
    logic [31:0]  chain_reg [NUM_CHAIN];
    logic [31:0]  chain_next [NUM_CHAIN];
    logic [31:0]  sched_reg [NUM_BLOCK];
    logic [31:0]  sched_next [NUM_BLOCK];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;

    logic         msg_accept;
    logic         block_full;
    logic [5:0]   pos;
    logic [63:0]  bit_len;
    logic         start_compress;
    logic [31:0]  f_val, k_val, w_new, round_sum;

    assign msg_accept = msg_valid && !msg_stall;
    assign pos        = count_reg[5:0];
    assign block_full = msg.byte_valid && (pos == 6'd63);
    assign bit_len    = {count_reg, 3'b000};

    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  value);
        logic [31:0] res;
        res = word;
        unique case (lane)
            2'd0: res = {value, 24'h0};
            2'd1: res[23:16] = value;
            2'd2: res[15:8]  = value;
            2'd3: res[7:0]   = value;
        endcase
        return res;
    endfunction

    // round function and constant by round group
    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    // schedule taps: sched_reg[0] is w[t], the new word is w[t+16]
    always_comb
    begin
        logic [31:0] mix;
        mix       = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new     = {mix[30:0], mix[31]};
        round_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + sched_reg[0] + k_val;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    if (block_full)
                        state_next = ST_ROUND;
                    else if (msg.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 7'(NUM_ROUNDS - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
                state_next = ret_reg;
            ST_PAD:
                state_next = ST_ROUND;
            ST_PAD2:
                state_next = ST_ROUND;
            ST_OUT:
            begin
                if (!digest_stall && idx_reg == 3'(NUM_CHAIN - 1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign start_compress = (state_next == ST_ROUND) && (state_reg != ST_ROUND);

    // datapath
    always_comb
    begin
        ret_next   = ret_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        chain_next = chain_reg;
        sched_next = sched_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    if (msg.byte_valid)
                    begin
                        sched_next[pos[5:2]] = put_byte(sched_reg[pos[5:2]], pos[1:0],
                                                        msg.data_byte);
                        count_next = count_reg + 61'd1;
                    end
                    ret_next = msg.end_of_message ? ST_PAD : ST_IDLE;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < NUM_BLOCK - 1; i++)
                    sched_next[i] = sched_reg[i + 1];
                sched_next[NUM_BLOCK - 1] = w_new;
                a_next     = round_sum;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
            end
            ST_PAD:
            begin
                sched_next[pos[5:2]] = put_byte(sched_reg[pos[5:2]], pos[1:0], PAD_MARK);
                for (int i = 0; i < NUM_BLOCK; i++)
                begin
                    if (4'(i) > pos[5:2])
                        sched_next[i] = '0;
                end
                // no room for the length below byte 56: it goes in an extra block
                if (pos[5:3] == 3'b111)
                    ret_next = ST_PAD2;
                else
                begin
                    sched_next[14] = bit_len[63:32];
                    sched_next[15] = bit_len[31:0];
                    ret_next       = ST_OUT;
                end
            end
            ST_PAD2:
            begin
                for (int i = 0; i < NUM_BLOCK; i++)
                    sched_next[i] = '0;
                sched_next[14] = bit_len[63:32];
                sched_next[15] = bit_len[31:0];
                ret_next       = ST_OUT;
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    if (idx_reg == 3'(NUM_CHAIN - 1))
                    begin
                        idx_next   = '0;
                        count_next = '0;
                        chain_next = H_INIT;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (start_compress)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            e_next     = chain_reg[4];
            round_next = '0;
        end
    end

    // outputs
    always_comb
    begin
        msg_stall    = (state_reg != ST_IDLE);
        digest_valid = (state_reg == ST_OUT);
        digest.word_index = idx_reg;
        digest.last_word  = (idx_reg == 3'(NUM_CHAIN - 1));
        unique case (idx_reg)
            3'd0:    digest.digest_word = chain_reg[0];
            3'd1:    digest.digest_word = chain_reg[1];
            3'd2:    digest.digest_word = chain_reg[2];
            3'd3:    digest.digest_word = chain_reg[3];
            3'd4:    digest.digest_word = chain_reg[4];
            default: digest.digest_word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            chain_reg <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg < 7'(NUM_ROUNDS)))
        else $error("round counter out of range");

    a_full_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_accept && block_full) |=> (state_reg == ST_ROUND && round_reg == 7'd0))
        else $error("full block did not start compression");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && digest.last_word)
        |=> (count_reg == 61'd0 && chain_reg[0] == H_INIT[0] && state_reg == ST_IDLE))
        else $error("no re-init after last digest word");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (idx_reg <= 3'(NUM_CHAIN - 1)))
        else $error("digest index out of range");

    a_add_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 7'(NUM_ROUNDS - 1)) |=> (state_reg == ST_ADD))
        else $error("chain add missed after last round");

endmodule

`default_nettype wire
